// File: src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg: shared definitions for the sample playback mixer
// Function codes, play modes, CSR indexes, sizes and derived widths.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int MAX_SAMPLES   = 64;
   localparam int AMBIENT_DEPTH = 4096;

   localparam int IDX_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int AMB_W     = $clog2(AMBIENT_DEPTH);
   localparam int LEN_W     = 16;
   localparam int PAGE_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 7;
   localparam int ENTRY_W   = LEN_W + PAGE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   localparam logic [BYTE_W-1:0] RAMP_TARGET = 8'd128;
   localparam logic [AMB_W-1:0]  AMB_LAST    = AMB_W'(AMBIENT_DEPTH - 1);

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_LOADED = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_LOADING = 2'd1,
      MODE_PLAYING = 2'd2
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd1;

endpackage

// File: src/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module spm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sample_playback_mixer.sv
// ----------------------------------------------------------------------------
// sample_playback_mixer: PWM sample player with looping ambient mix
// Plays table-described samples over an ambient loop and drives a PWM duty.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ channel and each gives exactly one result on the
// rsp_ channel. A transfer happens on a clock edge where valid is high and
// stall is low. Function codes: tick, start sample, page load done and
// table entry write. The sample table lives in a 64-entry RAM; a write is
// visible to any start that is transferred after it.
// An input transfer passes the input register and table read, then the state
// update into the result register, before its result can transfer.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result holds and one more item is taken into
// the input register; after that req_stall rises until the result moves.
// The csr_ port is always ready; the user must write it only while the block
// is idle, which the block does not enforce. Reset (synchronous) returns to
// idle with the duty, ambient position, held sample, length counter, enable
// and sample count cleared. Table contents are undefined until written.
// ----------------------------------------------------------------------------
module sample_playback_mixer (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [5:0]                       req_sample_index,
   input  logic [7:0]                       req_sample_byte,
   input  logic [7:0]                       req_ambient_sample,
   input  logic                             req_load_ok,
   input  logic [15:0]                      req_entry_length,
   input  logic [15:0]                      req_entry_page,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_duty,
   output logic                             rsp_page_request,
   output logic [15:0]                      rsp_page_number,
   output logic                             rsp_byte_request,
   output logic                             rsp_led_on,
   output logic [11:0]                      rsp_ambient_addr,
   output logic [1:0]                       rsp_play_status,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [spm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spm_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   localparam int IDX_W  = spm_pkg::IDX_W;
   localparam int AMB_W  = spm_pkg::AMB_W;
   localparam int LEN_W  = spm_pkg::LEN_W;
   localparam int PAGE_W = spm_pkg::PAGE_W;
   localparam int BYTE_W = spm_pkg::BYTE_W;

   // Handshake and stage control.
   logic req_accept;
   logic out_free;
   logic s1_fire;

   // Configuration registers.
   logic                           enable_ff;
   logic [spm_pkg::COUNT_W-1:0]    sample_count_ff;

   // Input register.
   logic                           s1_valid_ff;
   spm_pkg::func_type              s1_func_ff;
   logic [5:0]                     s1_index_ff;
   logic [BYTE_W-1:0]              s1_byte_ff;
   logic [BYTE_W-1:0]              s1_amb_ff;
   logic                           s1_ok_ff;

   // Table RAM.
   logic                           tbl_wr_en;
   logic [spm_pkg::ENTRY_W-1:0]    tbl_rd_data;
   logic [LEN_W-1:0]               tbl_length;
   logic [PAGE_W-1:0]              tbl_page;

   // Player state.
   spm_pkg::mode_type              mode_ff, mode_in;
   logic [LEN_W-1:0]               remaining_ff, remaining_in;
   logic [BYTE_W-1:0]              held_ff, held_in;
   logic [AMB_W-1:0]               amb_pos_ff, amb_pos_in;
   logic [BYTE_W-1:0]              duty_ff, duty_in;

   // Per-item decode.
   logic                           tick_on;
   logic                           start_ok;
   logic                           byte_req;
   logic [BYTE_W-1:0]              ramp_held;
   logic [BYTE_W:0]                mix_sum;

   // Result register.
   logic                           rsp_valid_ff;
   logic [BYTE_W-1:0]              rsp_duty_ff;
   logic                           rsp_page_request_ff;
   logic [PAGE_W-1:0]              rsp_page_number_ff;
   logic                           rsp_byte_request_ff;
   logic                           rsp_led_on_ff;
   logic [AMB_W-1:0]               rsp_ambient_addr_ff;
   spm_pkg::mode_type              rsp_play_status_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         sample_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spm_pkg::CSR_ENABLE:       enable_ff       <= csr_wdata[0];
            spm_pkg::CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[spm_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- sample table
   // Writes go in at the transfer edge; a later start reads at its own
   // transfer edge, so it always sees earlier writes.
   assign tbl_wr_en = req_accept && (req_func == spm_pkg::FUNC_WRITE) &&
                      (32'(req_sample_index) < spm_pkg::MAX_SAMPLES);

   spm_ram #(
      .WIDTH (spm_pkg::ENTRY_W),
      .DEPTH (spm_pkg::MAX_SAMPLES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (IDX_W'(req_sample_index)),
      .wr_data ({req_entry_length, req_entry_page}),
      .rd_en   (req_accept),
      .rd_addr (IDX_W'(req_sample_index)),
      .rd_data (tbl_rd_data)
   );

   assign tbl_length = tbl_rd_data[spm_pkg::ENTRY_W-1:PAGE_W];
   assign tbl_page   = tbl_rd_data[PAGE_W-1:0];

   // -------------------------------------------------------- input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff  <= spm_pkg::func_type'(req_func);
         s1_index_ff <= req_sample_index;
         s1_byte_ff  <= req_sample_byte;
         s1_amb_ff   <= req_ambient_sample;
         s1_ok_ff    <= req_load_ok;
      end
   end

   // ------------------------------------------------------------ decode
   assign tick_on  = (s1_func_ff == spm_pkg::FUNC_TICK) && enable_ff;
   assign start_ok = (s1_func_ff == spm_pkg::FUNC_START) &&
                     (mode_ff == spm_pkg::MODE_IDLE) &&
                     ({1'b0, s1_index_ff} < sample_count_ff) &&
                     (32'(s1_index_ff) < spm_pkg::MAX_SAMPLES);
   assign byte_req = tick_on && (mode_ff == spm_pkg::MODE_PLAYING) &&
                     (remaining_ff != '0);

   always_comb begin
      ramp_held = held_ff;
      if (held_ff < spm_pkg::RAMP_TARGET) begin
         ramp_held = held_ff + 8'd1;
      end else if (held_ff > spm_pkg::RAMP_TARGET) begin
         ramp_held = held_ff - 8'd1;
      end
   end

   // ------------------------------------------------------------ next mode
   always_comb begin
      mode_in = mode_ff;
      case (s1_func_ff)
         spm_pkg::FUNC_TICK: begin
            if (tick_on && (mode_ff == spm_pkg::MODE_PLAYING) &&
                (remaining_ff == '0) && (held_ff == spm_pkg::RAMP_TARGET)) begin
               mode_in = spm_pkg::MODE_IDLE;
            end
         end
         spm_pkg::FUNC_START: begin
            if (start_ok) begin
               mode_in = spm_pkg::MODE_LOADING;
            end
         end
         spm_pkg::FUNC_LOADED: begin
            if (mode_ff == spm_pkg::MODE_LOADING) begin
               mode_in = s1_ok_ff ? spm_pkg::MODE_PLAYING : spm_pkg::MODE_IDLE;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------ datapath
   always_comb begin
      remaining_in = remaining_ff;
      held_in      = held_ff;
      amb_pos_in   = amb_pos_ff;
      duty_in      = duty_ff;
      mix_sum      = '0;
      if (start_ok) begin
         remaining_in = tbl_length;
      end
      if (tick_on) begin
         amb_pos_in = (amb_pos_ff == spm_pkg::AMB_LAST) ? '0 : amb_pos_ff + 1'b1;
         if (mode_ff != spm_pkg::MODE_PLAYING) begin
            duty_in = s1_amb_ff;
         end else if (remaining_ff != '0) begin
            // The duty uses the old held sample; the new byte is held after.
            remaining_in = remaining_ff - 1'b1;
            mix_sum      = {1'b0, held_ff} + {1'b0, s1_amb_ff};
            duty_in      = mix_sum[BYTE_W:1];
            held_in      = s1_byte_ff;
         end else begin
            held_in = ramp_held;
            mix_sum = {1'b0, ramp_held} + {1'b0, s1_amb_ff};
            duty_in = mix_sum[BYTE_W:1];
         end
      end
   end

   // ------------------------------------------------------------ state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= spm_pkg::MODE_IDLE;
         remaining_ff <= '0;
         held_ff      <= '0;
         amb_pos_ff   <= '0;
         duty_ff      <= '0;
      end else if (s1_fire) begin
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
         held_ff      <= held_in;
         amb_pos_ff   <= amb_pos_in;
         duty_ff      <= duty_in;
      end
   end

   // ------------------------------------------------------------ result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_duty_ff         <= duty_in;
         rsp_page_request_ff <= start_ok;
         rsp_page_number_ff  <= start_ok ? tbl_page : '0;
         rsp_byte_request_ff <= byte_req;
         rsp_led_on_ff       <= (mode_in == spm_pkg::MODE_PLAYING);
         rsp_ambient_addr_ff <= amb_pos_in;
         rsp_play_status_ff  <= mode_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_page_request = rsp_page_request_ff;
   assign rsp_page_number  = rsp_page_number_ff;
   assign rsp_byte_request = rsp_byte_request_ff;
   assign rsp_led_on       = rsp_led_on_ff;
   assign rsp_ambient_addr = 12'(rsp_ambient_addr_ff);
   assign rsp_play_status  = rsp_play_status_ff;

endmodule

// File: src/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker: port-level checks for the sample playback mixer
// Watches the top-level ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
module spm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_duty,
   input logic        rsp_page_request,
   input logic        rsp_byte_request,
   input logic        rsp_led_on,
   input logic [1:0]  rsp_play_status
);

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty))
      else $error("stalled result changed");

   // The input side only backs up when the result side is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // An accepted start always leaves the player loading.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_request |->
         rsp_play_status == spm_pkg::MODE_LOADING && !rsp_byte_request)
      else $error("page request outside loading");

   // A byte is only requested while playing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_request |-> rsp_led_on)
      else $error("byte request while not playing");

endmodule

bind sample_playback_mixer spm_checker u_spm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_duty         (rsp_duty),
   .rsp_page_request (rsp_page_request),
   .rsp_byte_request (rsp_byte_request),
   .rsp_led_on       (rsp_led_on),
   .rsp_play_status  (rsp_play_status)
);
